/* rtl/core/scw_pkg.sv */
// ----------------------------------------------------------------------------
// scw_pkg: shared types and constants for the steering command watchdog
// Item kinds, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package scw_pkg;

  localparam int ANGLE_W = 16;
  localparam int MS_W    = 16;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [MS_W-1:0]    ms_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_CMD  = 2'd1,
    FUNC_POLL = 2'd2
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd4;

endpackage

`default_nettype wire

/* rtl/core/steering_command_watchdog.sv */
// ----------------------------------------------------------------------------
// steering_command_watchdog: steering position with command-timeout guard
//
// Input channel (in_valid/in_ready) takes one beat per item: a millisecond
// tick, a steering command carrying in_angle, or a poll. Only a poll gives a
// result beat on the output channel (out_valid/out_ready) with the clamped
// position, the report flag and the timeout and recovery mode flags.
// An accepted beat lands in an input register; from there its state update
// is applied and, for a poll, the result register is loaded once free, so a
// result passes the input register and then the result register before its
// beat can be taken. Throughput is one item per cycle as long as no
// poll waits on the result register; back-to-back items see each other's
// effects. When the receiver stalls, a waiting poll holds in the input
// register behind the result register and in_ready drops; ticks and
// commands keep flowing while the result register is occupied only until a
// poll reaches the input register. The cfg channel is always ready and
// writes are expected only while the block is idle. Synchronous reset
// empties both registers, clears all counters and watchdog angles, leaves both
// modes off and loads the limit and period registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_command_watchdog #(
  parameter int COUNTER_BITS = 17
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [scw_pkg::FUNC_W-1:0]             in_func,
  input  wire logic signed [scw_pkg::ANGLE_W-1:0]     in_angle,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [scw_pkg::ANGLE_W-1:0]          out_position,
  output logic                                        out_report,
  output logic                                        out_timed_out,
  output logic                                        out_recovering,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [scw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [scw_pkg::MS_W-1:0]               cfg_data
);

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  localparam cnt_t CNT_ONE = cnt_t'(1);
  localparam cnt_t CNT_MAX = '1;

  // configuration
  scw_pkg::angle_t min_angle_r, max_angle_r;
  scw_pkg::ms_t    timeout_ms_r, recover_ms_r, report_period_r;

  // input register
  logic                       stg_valid_r;
  logic [scw_pkg::FUNC_W-1:0] stg_func_r;
  scw_pkg::angle_t            stg_angle_r;

  // watchdog state
  scw_pkg::angle_t target_r, target_nxt;
  scw_pkg::angle_t pending_r, pending_nxt;
  scw_pkg::angle_t current_r, current_nxt;
  logic            timeout_r, timeout_nxt;
  logic            recovery_r, recovery_nxt;
  cnt_t            cmd_cnt_r, cmd_cnt_nxt;
  cnt_t            rec_cnt_r, rec_cnt_nxt;
  cnt_t            rpt_cnt_r, rpt_cnt_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  scw_pkg::angle_t out_position_r;
  logic            out_report_r, out_timed_out_r, out_recovering_r;
  logic            res_report;

  logic            out_free, stg_go, stg_fire, stg_ready, poll_fire;
  scw_pkg::angle_t tgt_sel, lo_lim;
  cnt_t            timeout_ext, recover_ext, report_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign stg_go    = (stg_func_r != scw_pkg::FUNC_POLL) || out_free;
  assign stg_fire  = stg_valid_r && stg_go;
  assign stg_ready = !stg_valid_r || stg_go;
  assign poll_fire = stg_fire && (stg_func_r == scw_pkg::FUNC_POLL);

  assign in_ready  = stg_ready;
  assign cfg_ready = 1'b1;

  assign timeout_ext = cnt_t'(timeout_ms_r);
  assign recover_ext = cnt_t'(recover_ms_r);
  assign report_ext  = cnt_t'(report_period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r     <= scw_pkg::angle_t'(-32768);
      max_angle_r     <= scw_pkg::angle_t'(32767);
      timeout_ms_r    <= scw_pkg::ms_t'(100);
      recover_ms_r    <= scw_pkg::ms_t'(100);
      report_period_r <= scw_pkg::ms_t'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        scw_pkg::CFG_MIN_ANGLE:     min_angle_r     <= scw_pkg::angle_t'(cfg_data);
        scw_pkg::CFG_MAX_ANGLE:     max_angle_r     <= scw_pkg::angle_t'(cfg_data);
        scw_pkg::CFG_TIMEOUT_MS:    timeout_ms_r    <= cfg_data;
        scw_pkg::CFG_RECOVER_MS:    recover_ms_r    <= cfg_data;
        scw_pkg::CFG_REPORT_PERIOD: report_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (stg_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready && in_valid) begin
      stg_func_r  <= in_func;
      stg_angle_r <= in_angle;
    end
  end

  always_comb begin
    target_nxt   = target_r;
    pending_nxt  = pending_r;
    current_nxt  = current_r;
    timeout_nxt  = timeout_r;
    recovery_nxt = recovery_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    rec_cnt_nxt  = rec_cnt_r;
    rpt_cnt_nxt  = rpt_cnt_r;
    res_report   = 1'b0;
    tgt_sel      = target_r;
    lo_lim       = (min_angle_r > max_angle_r) ? max_angle_r : min_angle_r;

    if (stg_fire) begin
      case (stg_func_r)
        scw_pkg::FUNC_TICK: begin
          cmd_cnt_nxt = (cmd_cnt_r == CNT_MAX) ? cmd_cnt_r : cmd_cnt_r + CNT_ONE;
          rec_cnt_nxt = (rec_cnt_r == CNT_MAX) ? rec_cnt_r : rec_cnt_r + CNT_ONE;
          rpt_cnt_nxt = (rpt_cnt_r == CNT_MAX) ? rpt_cnt_r : rpt_cnt_r + CNT_ONE;
        end
        scw_pkg::FUNC_CMD: begin
          cmd_cnt_nxt = '0;
          pending_nxt = stg_angle_r;
          if (timeout_r) begin
            if (!recovery_r) begin
              recovery_nxt = 1'b1;
              rec_cnt_nxt  = '0;
            end
          end else begin
            target_nxt = stg_angle_r;
          end
        end
        scw_pkg::FUNC_POLL: begin
          if (!timeout_r) begin
            if (cmd_cnt_r > timeout_ext) begin
              timeout_nxt  = 1'b1;
              recovery_nxt = 1'b0;
              tgt_sel      = current_r;
            end
          end else if (recovery_r) begin
            if (cmd_cnt_r > recover_ext) begin
              recovery_nxt = 1'b0;
            end else if (rec_cnt_r >= recover_ext) begin
              timeout_nxt  = 1'b0;
              recovery_nxt = 1'b0;
              tgt_sel      = pending_r;
            end
          end
          target_nxt = tgt_sel;
          // clamp: lower limit first, upper limit wins
          if (tgt_sel < lo_lim) begin
            current_nxt = lo_lim;
          end else begin
            current_nxt = tgt_sel;
          end
          if (current_nxt > max_angle_r) begin
            current_nxt = max_angle_r;
          end
          if ((report_period_r != '0) && (rpt_cnt_r >= report_ext)) begin
            res_report  = 1'b1;
            rpt_cnt_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      pending_r  <= '0;
      current_r  <= '0;
      timeout_r  <= 1'b0;
      recovery_r <= 1'b0;
      cmd_cnt_r  <= '0;
      rec_cnt_r  <= '0;
      rpt_cnt_r  <= '0;
    end else begin
      target_r   <= target_nxt;
      pending_r  <= pending_nxt;
      current_r  <= current_nxt;
      timeout_r  <= timeout_nxt;
      recovery_r <= recovery_nxt;
      cmd_cnt_r  <= cmd_cnt_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      rpt_cnt_r  <= rpt_cnt_nxt;
    end
  end

  always_comb begin
    if (poll_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_fire) begin
      out_position_r   <= current_nxt;
      out_report_r     <= res_report;
      out_timed_out_r  <= timeout_nxt;
      out_recovering_r <= recovery_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_report     = out_report_r;
  assign out_timed_out  = out_timed_out_r;
  assign out_recovering = out_recovering_r;

endmodule

`default_nettype wire

/* rtl/core/scw_checker.sv */
// ----------------------------------------------------------------------------
// scw_checker: port-level checks for the steering command watchdog
// Watches the item and result channels and reset behavior from the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module scw_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [scw_pkg::FUNC_W-1:0]        in_func,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [scw_pkg::ANGLE_W-1:0] out_position,
  input wire logic                              out_timed_out,
  input wire logic                              out_recovering
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // recovery only runs inside timeout mode
  a_rec_in_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recovering |-> out_timed_out)
    else $error("recovering without timeout");

  // a fresh result comes from an accepted poll that passed the input and result registers
  a_rose_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_func == scw_pkg::FUNC_POLL), 2))
    else $error("result without an accepted poll");

endmodule

bind steering_command_watchdog scw_checker u_scw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_position   (out_position),
  .out_timed_out  (out_timed_out),
  .out_recovering (out_recovering)
);

`default_nettype wire

/* tb/steer_watch_checker.sv */
// ----------------------------------------------------------------------------
// steer_watch_checker: result predictor and scoreboard for the steering
// command watchdog
//
// Watches the item, result and register write channels. Keeps its own copy
// of the limits, periods, elapsed-time counters and mode flags, works out the
// status beat owed for every accepted poll and checks each result beat,
// field by field, against the oldest owed status.
// ----------------------------------------------------------------------------
module steer_watch_checker
  import scw_pkg::*;
#(
  parameter int COUNTER_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  angle_t               in_angle,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  angle_t               out_position,
  input  logic                 out_report,
  input  logic                 out_timed_out,
  input  logic                 out_recovering,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  ms_t                  cfg_data,
  output int                   fail_count,
  output int                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COUNTER_BITS-1:0] elapsed_t;

  typedef struct packed {
    angle_t position;
    logic   report;
    logic   timed_out;
    logic   recovering;
  } steer_status_t;

  localparam elapsed_t ELAPSED_MAX = '1;
  localparam int       SHOWN_MISMATCHES = 10;

  angle_t        min_lim;
  angle_t        max_lim;
  ms_t           timeout_lim;
  ms_t           recover_lim;
  ms_t           report_period;
  angle_t        target;
  angle_t        pending;
  angle_t        position;
  logic          timeout_mode;
  logic          recovery_mode;
  elapsed_t      since_cmd;
  elapsed_t      since_recover;
  elapsed_t      since_report;
  steer_status_t owed_status[$];
  int            mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic elapsed_t bump(input elapsed_t count);
    return (count == ELAPSED_MAX) ? count : count + 1'b1;
  endfunction

  task automatic log_mismatch(input string what, input steer_status_t want,
                              input steer_status_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%0t %s: expected pos=%0d rep=%0b tmo=%0b rec=%0b,",
               $time, what, $signed(want.position), want.report, want.timed_out,
               want.recovering);
      $display("    got pos=%0d rep=%0b tmo=%0b rec=%0b",
               $signed(got.position), got.report, got.timed_out, got.recovering);
    end
  endtask

  always @(posedge clk) begin : track_steering
    steer_status_t got;
    steer_status_t want;
    angle_t        low_lim;
    if (!rst_n) begin
      min_lim       = 16'sh8000;
      max_lim       = 16'sh7FFF;
      timeout_lim   = 16'd100;
      recover_lim   = 16'd100;
      report_period = 16'd100;
      target        = '0;
      pending       = '0;
      position      = '0;
      timeout_mode  = 1'b0;
      recovery_mode = 1'b0;
      since_cmd     = '0;
      since_recover = '0;
      since_report  = '0;
      owed_status.delete();
    end else begin
      // a poll result passes the input and result registers, so retire before predicting
      if (out_valid && out_ready) begin
        got.position   = out_position;
        got.report     = out_report;
        got.timed_out  = out_timed_out;
        got.recovering = out_recovering;
        if (owed_status.size() == 0) begin
          log_mismatch("result beat with nothing owed", '0, got);
        end else begin
          want = owed_status.pop_front();
          if (got.position !== want.position || got.report !== want.report ||
              got.timed_out !== want.timed_out || got.recovering !== want.recovering) begin
            log_mismatch("status mismatch", want, got);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_ANGLE:     min_lim = angle_t'(cfg_data);
          CFG_MAX_ANGLE:     max_lim = angle_t'(cfg_data);
          CFG_TIMEOUT_MS:    timeout_lim = cfg_data;
          CFG_RECOVER_MS:    recover_lim = cfg_data;
          CFG_REPORT_PERIOD: report_period = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_TICK: begin
            since_cmd     = bump(since_cmd);
            since_recover = bump(since_recover);
            since_report  = bump(since_report);
          end
          FUNC_CMD: begin
            since_cmd = '0;
            pending   = in_angle;
            if (timeout_mode) begin
              if (!recovery_mode) begin
                recovery_mode = 1'b1;
                since_recover = '0;
              end
            end else begin
              target = in_angle;
            end
          end
          FUNC_POLL: begin
            if (!timeout_mode) begin
              if (since_cmd > timeout_lim) begin
                timeout_mode  = 1'b1;
                recovery_mode = 1'b0;
                target        = position;
              end
            end else if (recovery_mode) begin
              if (since_cmd > recover_lim) begin
                recovery_mode = 1'b0;
              end else if (since_recover >= recover_lim) begin
                timeout_mode  = 1'b0;
                recovery_mode = 1'b0;
                target        = pending;
              end
            end
            // a lower limit above the upper one collapses onto it
            low_lim  = (min_lim > max_lim) ? max_lim : min_lim;
            position = (target < low_lim) ? low_lim : target;
            if (position > max_lim) position = max_lim;
            want.report = 1'b0;
            if (report_period != '0 && since_report >= report_period) begin
              want.report  = 1'b1;
              since_report = '0;
            end
            want.position   = position;
            want.timed_out  = timeout_mode;
            want.recovering = recovery_mode;
            owed_status.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fail_count   <= mismatches;
    results_owed <= owed_status.size();
  end

endmodule

/* tb/tb_steering_command_watchdog.sv */
// ----------------------------------------------------------------------------
// tb_steering_command_watchdog: stimulus and verdict for the steering command
// watchdog
//
// Drives directed items (angle extremes, clamping, timeout entry, recovery
// gap and completion, disabled reports, the unused item kind), then random
// traffic shaped as command streams, silences and recovery attempts under
// several register settings, a receiver hold-off, and a long tick run with
// reports off. The checker module scores results.
// ----------------------------------------------------------------------------
module tb_steering_command_watchdog;
  timeunit 1ns;
  timeprecision 1ps;

  import scw_pkg::*;

  localparam int                COUNTER_BITS  = 17;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
  localparam int                HOLD_CYCLES   = 80;
  localparam int                QUIET_LIMIT   = 2000;
  localparam int                SETTLE_CYCLES = 4;
  localparam int                IDLE_PCT      = 20;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [FUNC_W-1:0]    in_func   = FUNC_TICK;
  angle_t               in_angle  = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_ANGLE;
  ms_t                  cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  angle_t               out_position;
  logic                 out_report;
  logic                 out_timed_out;
  logic                 out_recovering;
  logic                 cfg_ready;
  int                   fail_count;
  int                   results_owed;
  int                   quiet_cycles = 0;
  bit                   gaps_on      = 1'b1;
  bit                   hold_req     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  steering_command_watchdog #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_angle      (in_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_report    (out_report),
    .out_timed_out (out_timed_out),
    .out_recovering(out_recovering),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  steer_watch_checker #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_angle      (in_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_report    (out_report),
    .out_timed_out (out_timed_out),
    .out_recovering(out_recovering),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic angle_t any_angle();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic ms_t short_ms(input int upper);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ms_t'($urandom_range(1, upper));
    endcase
  endfunction

  task automatic push_item(input logic [FUNC_W-1:0] func, input angle_t angle);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_angle <= angle;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every owed status, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input angle_t lo, input angle_t hi, input ms_t tmo,
                           input ms_t rec, input ms_t rpt);
    logic [CFG_IDX_W-1:0] idx [5];
    ms_t                  val [5];
    idx = '{CFG_MIN_ANGLE, CFG_MAX_ANGLE, CFG_TIMEOUT_MS, CFG_RECOVER_MS, CFG_REPORT_PERIOD};
    val = '{ms_t'(lo), ms_t'(hi), tmo, rec, rpt};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_regs();
    angle_t lo;
    angle_t hi;
    case ($urandom_range(0, 3))
      0: begin
        lo = 16'sh8000;
        hi = 16'sh7FFF;
      end
      1: begin
        lo = any_angle();
        hi = any_angle();
      end
      default: begin
        lo = -angle_t'($urandom_range(0, 3000));
        hi = angle_t'($urandom_range(0, 3000));
      end
    endcase
    load_regs(lo, hi, short_ms(25), short_ms(12), short_ms(20));
  endtask

  // traffic in episodes: steady commands, tick silences that may outlast the timeout,
  // recovery attempts with short gaps, and noise of any item kind
  task automatic run_traffic(input int count);
    int               sent;
    int               n;
    logic [FUNC_W-1:0] func;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(0, 3);
          repeat (n) push_item(FUNC_TICK, any_angle());
          push_item(FUNC_CMD, any_angle());
          push_item(FUNC_POLL, any_angle());
          sent += n + 2;
        end
        4, 5: begin
          n = $urandom_range(5, 30);
          repeat (n) push_item(FUNC_TICK, any_angle());
          push_item(FUNC_POLL, any_angle());
          sent += n + 1;
        end
        6, 7: begin
          repeat ($urandom_range(2, 6)) begin
            n = $urandom_range(0, 4);
            repeat (n) push_item(FUNC_TICK, any_angle());
            push_item(FUNC_CMD, any_angle());
            push_item(FUNC_POLL, any_angle());
            sent += n + 2;
          end
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            func = FUNC_W'($urandom_range(0, 3));
            push_item(func, any_angle());
            if (func != FUNC_UNUSED) sent++;
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: full range, angle extremes pass through
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sh7FFF);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sh8000);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_UNUSED, 16'sh5555);
    push_item(FUNC_POLL, '0);

    // narrow limits, then timeout entry, recovery gap and recovery done
    settle();
    load_regs(-16'sd100, 16'sd200, 16'd2, 16'd3, 16'd1);
    push_item(FUNC_CMD, 16'sh7FFF);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sh8000);
    push_item(FUNC_POLL, '0);
    repeat (3) push_item(FUNC_TICK, '0);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sd150);
    push_item(FUNC_POLL, '0);
    repeat (4) push_item(FUNC_TICK, '0);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sd50);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_CMD, 16'sd60);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_CMD, 16'sd70);
    repeat (2) push_item(FUNC_TICK, '0);
    push_item(FUNC_POLL, '0);

    // lower limit above upper, zero timeout, zero recovery, reports off
    settle();
    load_regs(16'sd500, 16'sd200, '0, '0, '0);
    push_item(FUNC_CMD, -16'sd5);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, 16'sd7);
    push_item(FUNC_POLL, '0);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       load_regs(16'sh7FFF, 16'sh8000, '1, '1, '1);
        1:       load_regs(16'sh8000, 16'sh7FFF, '0, '0, '0);
        default: random_regs();
      endcase
      gaps_on = (phase != 5);
      if (phase == 3) begin
        // stall the receiver and offer polls and ticks so that input backs up
        hold_req = 1'b1;
        repeat (40) push_item($urandom_range(0, 1) ? FUNC_POLL : FUNC_TICK, any_angle());
      end
      run_traffic(60);
    end

    // a long tick run with reports off, then poll
    settle();
    load_regs(16'sh8000, 16'sh7FFF, '1, '1, '0);
    push_item(FUNC_CMD, 16'sd1234);
    repeat (100) push_item(FUNC_TICK, any_angle());
    push_item(FUNC_POLL, '0);
    push_item(FUNC_CMD, -16'sd77);
    push_item(FUNC_POLL, '0);
    settle();
    load_regs(16'sh8000, 16'sh7FFF, '1, '1, '1);
    push_item(FUNC_POLL, '0);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/scw_pkg.sv
rtl/core/steering_command_watchdog.sv
rtl/core/scw_checker.sv
tb/steer_watch_checker.sv
tb/tb_steering_command_watchdog.sv
